// ===== sv/sli_pkg.sv =====
// shared types and constants for the sorted insertion list
// no dependencies; used by sli_cell and sorted_list_insert
package sli_pkg;

  localparam int unsigned ValW = 32;

  // per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic ins;   // insert the new word at its sorted place
    logic rot;   // rotate occupied cells one place toward the head
  } cell_ctl_t;

endpackage

// ===== sv/sli_cell.sv =====
// one storage cell of the sorted chain: holds a word, compares it to the new word
// and takes a word from its neighbor on insert or rotate; uses sli_pkg
module sli_cell (
  input  logic                       clk_i,
  input  sli_pkg::cell_ctl_t         ctl_i,
  input  logic signed [sli_pkg::ValW-1:0] new_val_i,
  input  logic                       occ_i,       // this cell holds a live word
  input  logic                       prev_occ_i,  // cell toward the head is live
  input  logic                       prev_ge_i,   // cell toward the head is >= new word
  input  logic signed [sli_pkg::ValW-1:0] prev_val_i,
  input  logic                       next_occ_i,
  input  logic signed [sli_pkg::ValW-1:0] next_val_i,
  input  logic signed [sli_pkg::ValW-1:0] head_val_i,
  output logic                       ge_o,
  output logic signed [sli_pkg::ValW-1:0] val_o
);

  logic signed [sli_pkg::ValW-1:0] val_q, val_d;

  assign ge_o  = occ_i && (val_q >= new_val_i);
  assign val_o = val_q;

  always_comb begin
    val_d = val_q;
    if (ctl_i.ins) begin
      if (prev_ge_i) begin
        val_d = prev_val_i;
      end else if (ge_o || (!occ_i && prev_occ_i)) begin
        val_d = new_val_i;
      end
    end else if (ctl_i.rot && occ_i) begin
      // the last occupied cell picks up the old head word
      val_d = next_occ_i ? next_val_i : head_val_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

// ===== sv/sorted_list_insert.sv =====
// sorted insertion list: a chain of sli_cell instances plus listing control
// uses sli_pkg and sli_cell
//
// usage
//   input channel: in_valid_i / in_stall_o with kind_i and value_i. kind 0
//   inserts value_i before the first stored word that is >= it (equal words
//   end up newest first); an insert produces no output word and is dropped
//   silently when the store already holds CAPACITY words.
//   kind 1 lists the store: one output word per stored value, ascending,
//   last_o set on the final one. An empty store gives a single word with
//   item_value_o zero and both last_o and empty_res_o set.
//   output channel: out_valid_o / out_stall_i with item_value_o, last_o,
//   empty_res_o, driven straight from an output register.
// timing
//   an insert is written into the chain as it is accepted and leaves the input unstalled.
//   a listing sends one word per stored word (one for an empty store); the input
//   is stalled for that whole run. The head cell feeds the output register and
//   the chain rotates one place per word sent, so after the run the store is
//   back in its original order. The list item first sets the listing state; the
//   first word then goes from the head cell into the output register once that
//   register is free, and is offered from there.
// reset
//   clears the fill count, the listing state and the output valid; the cell
//   contents are not reset and are only ever read below the fill count.
// stalls
//   while out_stall_i is high the output word holds and the chain waits.
module sorted_list_insert #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic signed [31:0]      value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [31:0]      item_value_o,
  output logic                    last_o,
  output logic                    empty_res_o
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  // fill count and listing control
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic            list_q, list_d;

  // output register
  logic                            out_valid_q, out_valid_d;
  logic signed [sli_pkg::ValW-1:0] out_val_q, out_val_d;
  logic                            out_last_q, out_last_d;
  logic                            out_empty_q, out_empty_d;

  // chain wiring
  sli_pkg::cell_ctl_t              ctl;
  logic                            occ      [CAPACITY];
  logic                            ge       [CAPACITY];
  logic signed [sli_pkg::ValW-1:0] cell_val [CAPACITY];

  logic in_accept;
  logic out_free;
  logic is_full;
  logic run_last;

  assign in_stall_o = list_q;
  assign in_accept  = in_valid_i && !list_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_full    = (count_q == CntW'(CAPACITY));
  assign run_last   = ((idx_q + CntW'(1)) == count_q);

  // broadcast command for the cells
  always_comb begin
    ctl.ins = in_accept && !kind_i && !is_full;
    ctl.rot = list_q && out_free && (count_q != '0);
  end

  // cell occupancy as a thermometer of the fill count
  for (genvar k = 0; k < CAPACITY; k++) begin : g_occ
    assign occ[k] = (CntW'(k) < count_q);
  end

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic                            p_occ, p_ge, n_occ;
    logic signed [sli_pkg::ValW-1:0] p_val, n_val;

    if (k == 0) begin : g_head
      assign p_occ = 1'b1;
      assign p_ge  = 1'b0;
      assign p_val = value_i;
    end else begin : g_body
      assign p_occ = occ[k-1];
      assign p_ge  = ge[k-1];
      assign p_val = cell_val[k-1];
    end

    if (k == CAPACITY - 1) begin : g_tail
      assign n_occ = 1'b0;
      assign n_val = cell_val[0];
    end else begin : g_mid
      assign n_occ = occ[k+1];
      assign n_val = cell_val[k+1];
    end

    sli_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .new_val_i  (value_i),
      .occ_i      (occ[k]),
      .prev_occ_i (p_occ),
      .prev_ge_i  (p_ge),
      .prev_val_i (p_val),
      .next_occ_i (n_occ),
      .next_val_i (n_val),
      .head_val_i (cell_val[0]),
      .ge_o       (ge[k]),
      .val_o      (cell_val[k])
    );
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    list_d      = list_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_val_d   = out_val_q;
    out_last_d  = out_last_q;
    out_empty_d = out_empty_q;

    if (ctl.ins) begin
      count_d = count_q + CntW'(1);
    end

    if (in_accept && kind_i) begin
      list_d = 1'b1;
      idx_d  = '0;
    end

    if (list_q && out_free) begin
      out_valid_d = 1'b1;
      if (count_q == '0) begin
        // empty store: a single flagged word
        out_val_d   = '0;
        out_last_d  = 1'b1;
        out_empty_d = 1'b1;
        list_d      = 1'b0;
      end else begin
        out_val_d   = cell_val[0];
        out_last_d  = run_last;
        out_empty_d = 1'b0;
        idx_d       = idx_q + CntW'(1);
        if (run_last) begin
          list_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      idx_q       <= '0;
      list_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      idx_q       <= idx_d;
      list_q      <= list_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output payload, held while stalled
  always_ff @(posedge clk_i) begin
    out_val_q   <= out_val_d;
    out_last_q  <= out_last_d;
    out_empty_q <= out_empty_d;
  end

  assign out_valid_o  = out_valid_q;
  assign item_value_o = out_val_q;
  assign last_o       = out_last_q;
  assign empty_res_o  = out_empty_q;

endmodule

// ===== sv/sli_checker.sv =====
// port-level assertions for sorted_list_insert, attached with bind
// depends only on the top-level ports
module sli_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               kind_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] item_value_o,
  input logic               last_o,
  input logic               empty_res_o
);

  // an empty-store word is the only word of its run and carries zero
  a_empty_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && empty_res_o) |-> (last_o && (item_value_o == 32'sd0)))
    else $error("empty result word malformed");

  // a list word holds still while the receiver stalls
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(item_value_o)
      && $stable(last_o) && $stable(empty_res_o)))
    else $error("stalled output word changed");

  // a listing run blocks the input until it ends
  a_list_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i) |=> in_stall_o)
    else $error("input not stalled during listing");

  // an insert never blocks the next word
  a_insert_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !kind_i) |=> !in_stall_o)
    else $error("input stalled after insert");

  // a run streams without gaps until its last word
  a_run_streams: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !last_o) |=> out_valid_o)
    else $error("gap inside listing run");

endmodule

bind sorted_list_insert sli_checker u_sli_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .kind_i       (kind_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .item_value_o (item_value_o),
  .last_o       (last_o),
  .empty_res_o  (empty_res_o)
);
